>>> sv/uvt_pkg.sv
// Shared types and constants for the UTF-8 / MQTT topic validator.
package uvt_pkg;

  // Check mode register codes
  localparam logic [1:0] ModePlain  = 2'd0;
  localparam logic [1:0] ModeName   = 2'd1;
  localparam logic [1:0] ModeFilter = 2'd2;

  // Verdict error codes
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrTooLong  = 3'd1;
  localparam logic [2:0] ErrUtf8     = 3'd2;
  localparam logic [2:0] ErrWildName = 3'd3;
  localparam logic [2:0] ErrHash     = 3'd4;
  localparam logic [2:0] ErrPlus     = 3'd5;

  // Register indexes
  localparam logic RegMode   = 1'b0;
  localparam logic RegMaxLen = 1'b1;

  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned CountWidth  = 17;
  localparam logic [15:0] MaxLenReset = 16'hFFFF;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Byte values used by the byte classifier, the UTF-8 range checks and the wildcard checks
  localparam logic [7:0] ByteLead2Lo = 8'hC2;
  localparam logic [7:0] ByteLead2Hi = 8'hDF;
  localparam logic [7:0] ByteLead3Lo = 8'hE0;
  localparam logic [7:0] ByteLead3Hi = 8'hEF;
  localparam logic [7:0] ByteLead4Lo = 8'hF0;
  localparam logic [7:0] ByteLead4Hi = 8'hF4;
  localparam logic [7:0] ByteA0      = 8'hA0;
  localparam logic [7:0] ByteED      = 8'hED;
  localparam logic [7:0] ByteBE      = 8'hBE;
  localparam logic [7:0] Byte90      = 8'h90;
  localparam logic [7:0] Byte8F      = 8'h8F;
  localparam logic [7:0] ByteBF      = 8'hBF;
  localparam logic [7:0] ByteCont    = 8'h80;
  localparam logic [7:0] ByteHash    = 8'h23;
  localparam logic [7:0] BytePlus    = 8'h2B;
  localparam logic [7:0] ByteSlash   = 8'h2F;
  localparam logic [7:0] ByteNul     = 8'h00;

  // Byte classes found by the front end
  typedef enum logic [2:0] {
    ClsNul   = 3'd0,
    ClsAscii = 3'd1,
    ClsLead2 = 3'd2,
    ClsLead3 = 3'd3,
    ClsLead4 = 3'd4,
    ClsCont  = 3'd5,
    ClsBad   = 3'd6
  } byte_cls_e;

  // Classified item held in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    byte_cls_e  cls;
    logic       is_hash;
    logic       is_plus;
    logic       is_slash;
    logic       last;
  } uvt_item_t;

  // Handshake between front end and queue
  typedef struct packed {
    logic valid;
    logic ready;
  } uvt_hs_t;

endpackage

>>> sv/uvt_if.sv
// Stream interfaces for the byte input and the verdict output.
interface uvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface uvt_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [2:0] error_code;

  modport source (output valid, output valid_res, output error_code, input ready);
  modport sink   (input valid, input valid_res, input error_code, output ready);
endinterface

>>> sv/utf8_mqtt_topic_validator_top.sv
// Top level of the UTF-8 / MQTT topic validator.
//
// in_i carries one string byte per item (data_byte, last); last marks the
// final byte. out_o carries one verdict per string (valid_res, error_code:
// 0 ok, 1 too long, 2 bad UTF-8, 3 wildcard in name, 4 misplaced hash,
// 5 misplaced plus). The APB port holds check_mode at 0x0 and max_length
// at 0x4; write them only while no string is in flight.
// Throughput: one byte per cycle unless a last byte waits on a stalled
// out_o. A byte is classified and written into a two-entry queue when it
// is accepted; the back end takes it from the queue and, for a last byte,
// loads the verdict register as it pops it, which drives out_o directly.
// When out_o stalls, the verdict holds and the back end keeps consuming
// non-last bytes; a following last byte waits in the queue, and in_i
// drops ready once both queue entries are filled.
// Reset clears all string state, the queue and the verdict valid flag but
// not its payload; check_mode returns to plain UTF-8, max_length to 65535.
module utf8_mqtt_topic_validator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  uvt_in_if.sink                        in_i,
  uvt_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uvt_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import uvt_pkg::*;

  logic [1:0]  mode_q;
  logic [15:0] max_len_q;
  logic        cfg_wr;
  uvt_item_t   push_item, pop_item;
  uvt_hs_t     push_hs;
  logic        push_ready, pop_valid, pop_ready;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModePlain;
      max_len_q <= MaxLenReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegMode:   mode_q    <= pwdata[1:0];
        RegMaxLen: max_len_q <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      RegMode:   prdata = {30'd0, mode_q};
      RegMaxLen: prdata = {16'd0, max_len_q};
      default:   prdata = 32'd0;
    endcase
  end

  uvt_front u_front (
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .last_i       (in_i.last),
    .push_item_o  (push_item),
    .push_hs_o    (push_hs),
    .push_ready_i (push_ready)
  );

  uvt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_hs_i    (push_hs),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  uvt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .check_mode_i (mode_q),
    .max_length_i (max_len_q),
    .item_i       (pop_item),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .valid_res_o  (out_o.valid_res),
    .error_code_o (out_o.error_code)
  );

endmodule

>>> sv/uvt_front.sv
// Front end: classifies each incoming byte and pushes it into the queue.
module uvt_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  output uvt_pkg::uvt_item_t push_item_o,
  output uvt_pkg::uvt_hs_t   push_hs_o,
  input  logic               push_ready_i
);
  import uvt_pkg::*;

  byte_cls_e cls;

  // UTF-8 byte class
  always_comb begin
    priority if (data_byte_i == ByteNul) begin
      cls = ClsNul;
    end else if (data_byte_i < ByteCont) begin
      cls = ClsAscii;
    end else if (data_byte_i <= ByteBF) begin
      cls = ClsCont;
    end else if (data_byte_i >= ByteLead2Lo && data_byte_i <= ByteLead2Hi) begin
      cls = ClsLead2;
    end else if (data_byte_i >= ByteLead3Lo && data_byte_i <= ByteLead3Hi) begin
      cls = ClsLead3;
    end else if (data_byte_i >= ByteLead4Lo && data_byte_i <= ByteLead4Hi) begin
      cls = ClsLead4;
    end else begin
      cls = ClsBad;
    end
  end

  // Item toward the queue
  always_comb begin
    push_item_o.data_byte = data_byte_i;
    push_item_o.cls       = cls;
    push_item_o.is_hash   = (data_byte_i == ByteHash);
    push_item_o.is_plus   = (data_byte_i == BytePlus);
    push_item_o.is_slash  = (data_byte_i == ByteSlash);
    push_item_o.last      = last_i;
  end

  assign push_hs_o.valid = in_valid_i;
  assign push_hs_o.ready = push_ready_i;
  assign in_ready_o      = push_ready_i;

endmodule

>>> sv/uvt_queue.sv
// Two-entry queue between the front end and the back end.
module uvt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uvt_pkg::uvt_item_t push_item_i,
  input  uvt_pkg::uvt_hs_t   push_hs_i,
  output logic               push_ready_o,
  output uvt_pkg::uvt_item_t pop_item_o,
  output logic               pop_valid_o,
  input  logic               pop_ready_i
);
  import uvt_pkg::*;

  uvt_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_hs_i.valid && push_hs_i.ready;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> sv/uvt_back.sv
// Back end: per-string UTF-8 and wildcard state, verdict output register.
module uvt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         check_mode_i,
  input  logic [15:0]        max_length_i,
  input  uvt_pkg::uvt_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic [2:0]         error_code_o
);
  import uvt_pkg::*;

  logic [1:0]            owed_q, owed_d;
  logic [7:0]            lead_q, lead_d;
  logic                  swt_q, swt_d;
  logic                  prior_slash_q, prior_slash_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  fail_q, fail_d;
  logic [2:0]            werr_q, werr_d;
  logic                  plus_open_q, plus_open_d;
  logic                  hash_seen_q, hash_seen_d;
  logic                  out_valid_q, out_valid_d;
  logic                  valid_res_q, valid_res_d;
  logic [2:0]            code_q, code_d;
  logic                  pop, first, topic, at_start, str_end, utf8_err;
  logic [2:0]            wild_new, werr_upd, code;
  logic [7:0]            b;

  assign b            = item_i.data_byte;
  assign topic        = (check_mode_i == ModeName) || (check_mode_i == ModeFilter);
  assign at_start     = (count_q == '0);
  // a last byte needs a free output slot
  assign item_ready_o = !item_i.last || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign str_end      = pop && item_i.last;

  // UTF-8 decoder state
  always_comb begin
    owed_d = owed_q;
    lead_d = lead_q;
    swt_d  = swt_q;
    fail_d = fail_q;
    first  = 1'b0;
    if (pop && !fail_q) begin
      if (owed_q == 2'd0) begin
        lead_d = b;
        swt_d  = 1'b0;
        unique case (item_i.cls)
          ClsAscii: owed_d = 2'd0;
          ClsLead2: owed_d = 2'd1;
          ClsLead3: owed_d = 2'd2;
          ClsLead4: owed_d = 2'd3;
          default:  fail_d = 1'b1;
        endcase
      end else if (item_i.cls != ClsCont) begin
        fail_d = 1'b1;
      end else begin
        priority if (lead_q >= ByteLead4Lo) begin
          first = (owed_q == 2'd3);
        end else if (lead_q >= ByteLead3Lo) begin
          first = (owed_q == 2'd2);
        end else begin
          first = (owed_q == 2'd1);
        end
        if (first) begin
          // overlong, surrogate and above-range checks on the second byte
          if ((lead_q == ByteLead3Lo && b < ByteA0) ||
              (lead_q == ByteED && b >= ByteA0) ||
              (lead_q == ByteLead4Lo && b < Byte90) ||
              (lead_q == ByteLead4Hi && b > Byte8F)) begin
            fail_d = 1'b1;
          end
          swt_d = (b == ByteBF);
        end else if (lead_q == ByteLead3Hi && owed_q == 2'd1 && swt_q &&
                     (b == ByteBE || b == ByteBF)) begin
          // U+FFFE and U+FFFF
          fail_d = 1'b1;
        end
        owed_d = owed_q - 2'd1;
      end
    end
    // UTF-8 verdict including this byte, taken before the end-of-string clear
    utf8_err = fail_d || (owed_d != 2'd0);
    if (str_end) begin
      owed_d = 2'd0;
      lead_d = 8'd0;
      swt_d  = 1'b0;
      fail_d = 1'b0;
    end
  end

  // Wildcard rules, first error in the string wins
  always_comb begin
    wild_new    = ErrNone;
    plus_open_d = plus_open_q;
    hash_seen_d = hash_seen_q;
    if (pop) begin
      if (check_mode_i == ModeName) begin
        if (item_i.is_hash || item_i.is_plus) wild_new = ErrWildName;
      end else if (check_mode_i == ModeFilter) begin
        if (hash_seen_q) wild_new = ErrHash;
        if (plus_open_q) begin
          if (!item_i.is_slash && wild_new == ErrNone) wild_new = ErrPlus;
          plus_open_d = 1'b0;
        end
        if (item_i.is_hash) begin
          hash_seen_d = 1'b1;
          if (!at_start && !prior_slash_q && wild_new == ErrNone) wild_new = ErrHash;
        end else if (item_i.is_plus) begin
          if (!at_start && !prior_slash_q) begin
            if (wild_new == ErrNone) wild_new = ErrPlus;
          end else if (!item_i.last) begin
            plus_open_d = 1'b1;
          end
        end
      end
    end
    werr_upd = (werr_q == ErrNone) ? wild_new : werr_q;
    werr_d   = str_end ? ErrNone : werr_upd;
    if (str_end) begin
      plus_open_d = 1'b0;
      hash_seen_d = 1'b0;
    end
  end

  // Length count, previous byte, verdict and end-of-string clear
  always_comb begin
    prior_slash_d = prior_slash_q;
    count_d       = count_q;
    if (pop) begin
      prior_slash_d = item_i.is_slash;
      if (count_q != CountMax) count_d = count_q + CountWidth'(1);
    end

    priority if (topic && count_d > {1'b0, max_length_i}) begin
      code = ErrTooLong;
    end else if (utf8_err) begin
      code = ErrUtf8;
    end else if (topic) begin
      code = werr_upd;
    end else begin
      code = ErrNone;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    valid_res_d = valid_res_q;
    code_d      = code_q;
    if (str_end) begin
      out_valid_d   = 1'b1;
      valid_res_d   = (code == ErrNone);
      code_d        = code;
      prior_slash_d = 1'b0;
      count_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q        <= 2'd0;
      lead_q        <= 8'd0;
      swt_q         <= 1'b0;
      prior_slash_q <= 1'b0;
      count_q       <= '0;
      fail_q        <= 1'b0;
      werr_q        <= ErrNone;
      plus_open_q   <= 1'b0;
      hash_seen_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      owed_q        <= owed_d;
      lead_q        <= lead_d;
      swt_q         <= swt_d;
      prior_slash_q <= prior_slash_d;
      count_q       <= count_d;
      fail_q        <= fail_d;
      werr_q        <= werr_d;
      plus_open_q   <= plus_open_d;
      hash_seen_q   <= hash_seen_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Verdict payload
  always_ff @(posedge clk_i) begin
    valid_res_q <= valid_res_d;
    code_q      <= code_d;
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = valid_res_q;
  assign error_code_o = code_q;

endmodule

>>> sv/uvt_checker.sv
// Port-level checks on the validator, bound to the top level.
module uvt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       valid_res_i,
  input logic [2:0] error_code_i
);
  import uvt_pkg::*;

  // A stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(valid_res_i) &&
    $stable(error_code_i))
    else $error("verdict changed while stalled");

  // The pass flag agrees with the error code
  a_res_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (valid_res_i == (error_code_i == ErrNone)))
    else $error("valid_res disagrees with error_code");

  // Only defined error codes appear
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (error_code_i <= ErrPlus))
    else $error("undefined error code");

  // No verdict while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("verdict shown during reset");

endmodule

bind utf8_mqtt_topic_validator_top uvt_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .valid_res_i  (out_o.valid_res),
  .error_code_i (out_o.error_code)
);
